[hw/rtl/wcsa_pkg.sv]
// ----------------------------------------------------------------------------
// wcsa_pkg
// Shared widths, reset values, register codes and helpers for the windowed
// current-sense average.
// ----------------------------------------------------------------------------
package wcsa_pkg;

  // field widths
  localparam int unsigned SAMPLE_W   = 10;
  localparam int unsigned GAIN_W     = 8;
  localparam int unsigned CUR_W      = 16;
  localparam int unsigned INST_P_W   = SAMPLE_W + GAIN_W;

  // configuration port widths
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;

  // default window
  localparam int unsigned WINDOW_DEF      = 64;
  localparam int unsigned WINDOW_LOG2_DEF = 6;

  // register reset values
  localparam logic [SAMPLE_W-1:0] OFFSET_RESET = SAMPLE_W'(504);
  localparam logic [GAIN_W-1:0]   GAIN_RESET   = GAIN_W'(48);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ZERO_OFFSET = 8'd0,
    REG_GAIN        = 8'd1
  } cfg_reg_e;

  // clamp an instant-current product to the output width
  function automatic logic [CUR_W-1:0] sat_inst(input logic [INST_P_W-1:0] p);
    logic [CUR_W-1:0] r;
    if (|p[INST_P_W-1:CUR_W]) begin
      r = '1;
    end else begin
      r = p[CUR_W-1:0];
    end
    return r;
  endfunction

endpackage

[hw/rtl/wcsa_ring.sv]
// ----------------------------------------------------------------------------
// wcsa_ring
// Sample ring: one synchronous memory of WINDOW samples, written at the
// current slot while the previous occupant of that slot is read out.
// ----------------------------------------------------------------------------
module wcsa_ring import wcsa_pkg::*; #(
  parameter int unsigned WINDOW = WINDOW_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  logic [SAMPLE_W-1:0] wr_data_i,
  output logic [SAMPLE_W-1:0] old_o
);

  localparam int unsigned SLOT_W = $clog2(WINDOW);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);

  logic [SAMPLE_W-1:0] mem [WINDOW];
  logic [SAMPLE_W-1:0] rd_q;
  logic                hit_q;
  logic [WINDOW-1:0]   vld_q;
  logic [SLOT_W-1:0]   slot_q, slot_d;

  // next slot with wrap
  always_comb begin
    slot_d = slot_q;
    if (wr_en_i) begin
      slot_d = (slot_q == SLOT_LAST) ? '0 : slot_q + 1'b1;
    end
  end

  // slot pointer and written-entry flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      vld_q  <= '0;
      hit_q  <= 1'b0;
    end else begin
      slot_q <= slot_d;
      if (wr_en_i) begin
        vld_q[slot_q] <= 1'b1;
        hit_q         <= vld_q[slot_q];
      end
    end
  end

  // memory: old data comes out while the new sample goes in
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      rd_q         <= mem[slot_q];
      mem[slot_q]  <= wr_data_i;
    end
  end

  // never-written slots read as zero
  assign old_o = hit_q ? rd_q : '0;

`ifndef NO_ASSERTIONS
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= SLOT_LAST)
    else $error("ring slot pointer out of range");

  a_wr_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_i |=> vld_q[$past(slot_q)])
    else $error("written slot not marked valid");
`endif

endmodule

[hw/rtl/wcsa_calc.sv]
// ----------------------------------------------------------------------------
// wcsa_calc
// Running window sum and calibration pipeline: sum update, magnitudes,
// gain multiply, shift and saturation, output register.
// ----------------------------------------------------------------------------
module wcsa_calc import wcsa_pkg::*; #(
  parameter int unsigned WINDOW      = WINDOW_DEF,
  parameter int unsigned WINDOW_LOG2 = WINDOW_LOG2_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [SAMPLE_W-1:0] in_sample_i,
  input  logic [SAMPLE_W-1:0] old_i,
  input  logic [SAMPLE_W-1:0] zero_offset_i,
  input  logic [GAIN_W-1:0]   gain_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [CUR_W-1:0]    average_current_o,
  output logic [CUR_W-1:0]    instant_current_o
);

  localparam int unsigned SUM_W   = SAMPLE_W + $clog2(WINDOW);
  localparam int unsigned AVG_P_W = SUM_W + GAIN_W;
  localparam logic [SUM_W-1:0] SUM_MAX = SUM_W'(WINDOW * ((1 << SAMPLE_W) - 1));

  logic adv;

  logic                s1_valid_q;
  logic [SAMPLE_W-1:0] s1_sample_q;
  logic                s2_valid_q;
  logic [SAMPLE_W-1:0] s2_sample_q;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic                s3_valid_q;
  logic [SUM_W-1:0]    avg_mag_q;
  logic [SAMPLE_W-1:0] inst_mag_q;
  logic                s4_valid_q;
  logic [AVG_P_W-1:0]  avg_prod_q;
  logic [INST_P_W-1:0] inst_prod_q;
  logic                out_valid_q;
  logic [CUR_W-1:0]    avg_out_q;
  logic [CUR_W-1:0]    inst_out_q;

  logic [SUM_W-1:0]    offset_sum;
  logic [SUM_W-1:0]    avg_mag_d;
  logic [SAMPLE_W-1:0] inst_mag_d;
  logic [AVG_P_W-1:0]  avg_shift;
  logic [CUR_W-1:0]    avg_sat;

  // whole pipeline moves when the output register is free or drained
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  // running sum: drop the overwritten sample, add the new one
  assign sum_d = sum_q - SUM_W'(old_i) + SUM_W'(s1_sample_q);

  // magnitudes against the zero-current code
  assign offset_sum = SUM_W'(zero_offset_i) * SUM_W'(WINDOW);
  assign avg_mag_d  = (sum_q > offset_sum) ? sum_q - offset_sum : offset_sum - sum_q;
  assign inst_mag_d = (s2_sample_q > zero_offset_i) ? s2_sample_q - zero_offset_i
                                                    : zero_offset_i - s2_sample_q;

  // window average shift and clamp
  assign avg_shift = avg_prod_q >> WINDOW_LOG2;
  always_comb begin
    if (|avg_shift[AVG_P_W-1:CUR_W]) begin
      avg_sat = '1;
    end else begin
      avg_sat = avg_shift[CUR_W-1:0];
    end
  end

  // stage valids and running sum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      sum_q       <= '0;
    end else if (adv) begin
      s1_valid_q  <= in_valid_i;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      s4_valid_q  <= s3_valid_q;
      out_valid_q <= s4_valid_q;
      if (s1_valid_q) begin
        sum_q <= sum_d;
      end
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_sample_q <= in_sample_i;
      s2_sample_q <= s1_sample_q;
      avg_mag_q   <= avg_mag_d;
      inst_mag_q  <= inst_mag_d;
      avg_prod_q  <= AVG_P_W'(avg_mag_q) * AVG_P_W'(gain_i);
      inst_prod_q <= INST_P_W'(inst_mag_q) * INST_P_W'(gain_i);
      avg_out_q   <= avg_sat;
      inst_out_q  <= sat_inst(inst_prod_q);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign average_current_o = avg_out_q;
  assign instant_current_o = inst_out_q;

`ifndef NO_ASSERTIONS
  a_sum_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_q <= SUM_MAX)
    else $error("window sum beyond full-scale window");

  a_sum_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(sum_q))
    else $error("window sum changed during stall");

  a_last_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && s4_valid_q |=> out_valid_q)
    else $error("result lost at output register");
`endif

endmodule

[hw/rtl/windowed_current_sense_average.sv]
// ----------------------------------------------------------------------------
// windowed_current_sense_average
// Moving-average current sense over a ring of converter samples.
// ----------------------------------------------------------------------------
// Each transfer on the input stream carries one 10-bit converter sample and
// produces one output transfer holding the window-averaged current and the
// instant current, both calibrated by the gain register and clamped to 16
// bits. The block takes one sample per clock unless the output stream
// stalls; a result passes the s1, s2, magnitude, product and output
// registers, and stalls on the output stream hold the whole pipeline. The
// rate is set by the single sample ring memory, which reads the oldest
// sample and writes the new one at the same slot in the transfer cycle. The
// ring starts empty after reset (slots not yet written count as zero), so no
// clearing pass is needed. The user must write zero_offset (index 0) and gain
// (index 1) over the configuration channel only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module windowed_current_sense_average import wcsa_pkg::*; #(
  parameter int unsigned WINDOW      = WINDOW_DEF,
  parameter int unsigned WINDOW_LOG2 = WINDOW_LOG2_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [15:0]           s_axis_tdata,   // [9:0] sample
  // output stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [31:0]           m_axis_tdata,   // [15:0] average_current, [31:16] instant_current
  // configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [SAMPLE_W-1:0] zero_offset_q;
  logic [GAIN_W-1:0]   gain_q;
  logic                in_xfer;
  logic [SAMPLE_W-1:0] old_sample;
  logic [CUR_W-1:0]    avg_cur;
  logic [CUR_W-1:0]    inst_cur;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_offset_q <= OFFSET_RESET;
      gain_q        <= GAIN_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_ZERO_OFFSET: zero_offset_q <= cfg_data_i[SAMPLE_W-1:0];
        REG_GAIN:        gain_q        <= cfg_data_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_xfer = s_axis_tvalid && s_axis_tready;

  // sample ring
  wcsa_ring #(
    .WINDOW (WINDOW)
  ) u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (in_xfer),
    .wr_data_i (s_axis_tdata[SAMPLE_W-1:0]),
    .old_o     (old_sample)
  );

  // sum and calibration pipeline
  wcsa_calc #(
    .WINDOW      (WINDOW),
    .WINDOW_LOG2 (WINDOW_LOG2)
  ) u_calc (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (s_axis_tvalid),
    .in_ready_o        (s_axis_tready),
    .in_sample_i       (s_axis_tdata[SAMPLE_W-1:0]),
    .old_i             (old_sample),
    .zero_offset_i     (zero_offset_q),
    .gain_i            (gain_q),
    .out_valid_o       (m_axis_tvalid),
    .out_ready_i       (m_axis_tready),
    .average_current_o (avg_cur),
    .instant_current_o (inst_cur)
  );

  assign m_axis_tdata = {inst_cur, avg_cur};

endmodule

[verif/windowed_current_sense_average_tb.sv]
// ----------------------------------------------------------------------------
// windowed_current_sense_average_tb
// Self-checking bench for the windowed current-sense average.
// ----------------------------------------------------------------------------
// A directed table covers reset defaults, the start-up window, zero and full
// gain, offset extremes, ignored register indexes and over-wide register
// values. Random samples then run in three phases with different register
// settings and idle patterns. A long output hold-off and a drain pause are
// included. Every output transfer is checked against an in-bench moving
// average model.
// ----------------------------------------------------------------------------
module windowed_current_sense_average_tb;
  import wcsa_pkg::*;

  localparam int unsigned WIN           = WINDOW_DEF;
  localparam int unsigned WIN_LOG2      = WINDOW_LOG2_DEF;
  localparam int unsigned PHASE_ITEMS   = 330;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned TAIL_CYCLES   = 20;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam int unsigned LIMIT_TIME    = 2_000_000;

  // one output transfer, laid out as m_axis_tdata
  typedef struct packed {
    logic [CUR_W-1:0] inst;
    logic [CUR_W-1:0] avg;
  } currents_t;

  typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_e;

  // directed stimulus row
  typedef struct {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] value;
    logic                  chk_avg;
    logic                  chk_inst;
    logic [CUR_W-1:0]      avg;
    logic [CUR_W-1:0]      inst;
  } dir_row_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [15:0]           s_axis_tdata  = '0;   // [9:0] sample
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [31:0]           m_axis_tdata;         // [15:0] average_current, [31:16] instant_current
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  // model of the block
  logic [SAMPLE_W-1:0]   ring_model [WIN];
  int unsigned           slot_model;
  logic [31:0]           sum_model;
  logic [SAMPLE_W-1:0]   offset_reg;
  logic [GAIN_W-1:0]     gain_reg;

  currents_t             expected_currents [$];
  dir_row_t              dir_rows [$];
  int unsigned           mismatch_cnt  = 0;
  int unsigned           send_idle_pct = 0;
  int unsigned           recv_idle_pct = 0;
  int unsigned           hold_left     = 0;

  windowed_current_sense_average #(
    .WINDOW      (WIN),
    .WINDOW_LOG2 (WIN_LOG2)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #(LIMIT_TIME);
    $display("FAIL");
    $finish;
  end

  // ring update, then averaged and instant magnitudes with clamping
  function automatic currents_t predict_currents(input logic [SAMPLE_W-1:0] smp);
    logic [31:0] offset_sum;
    logic [31:0] sum_diff;
    logic [47:0] avg_full;
    logic [31:0] inst_full;
    currents_t   r;
    sum_model              = sum_model - 32'(ring_model[slot_model]) + 32'(smp);
    ring_model[slot_model] = smp;
    slot_model             = (slot_model == WIN - 1) ? 0 : slot_model + 1;
    offset_sum = 32'(offset_reg) * WIN;
    sum_diff  = (sum_model > offset_sum) ? sum_model - offset_sum
                                         : offset_sum - sum_model;
    avg_full  = (48'(sum_diff) * 48'(gain_reg)) >> WIN_LOG2;
    inst_full = (smp > offset_reg) ? 32'(smp) - 32'(offset_reg)
                                   : 32'(offset_reg) - 32'(smp);
    inst_full = inst_full * 32'(gain_reg);
    r.avg  = (avg_full > 48'hFFFF) ? '1 : avg_full[CUR_W-1:0];
    r.inst = (inst_full > 32'hFFFF) ? '1 : inst_full[CUR_W-1:0];
    return r;
  endfunction

  function automatic dir_row_t srow(input logic [SAMPLE_W-1:0] smp, input logic chk_avg,
                                    input logic [CUR_W-1:0] avg, input logic chk_inst,
                                    input logic [CUR_W-1:0] inst);
    dir_row_t r;
    r.kind     = ROW_SAMPLE;
    r.index    = '0;
    r.value    = CFG_DATA_W'(smp);
    r.chk_avg  = chk_avg;
    r.chk_inst = chk_inst;
    r.avg      = avg;
    r.inst     = inst;
    return r;
  endfunction

  function automatic dir_row_t crow(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] value);
    dir_row_t r;
    r          = srow('0, 1'b0, '0, 1'b0, '0);
    r.kind     = ROW_CFG;
    r.index    = idx;
    r.value    = value;
    return r;
  endfunction

  task automatic wait_drained();
    while (expected_currents.size() != 0) @(posedge clk_i);
  endtask

  // one sample transfer, with random idle cycles ahead of it
  task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic chk_avg,
                             input logic [CUR_W-1:0] avg, input logic chk_inst,
                             input logic [CUR_W-1:0] inst);
    currents_t want;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= 16'(smp);
    do @(posedge clk_i); while (!s_axis_tready);
    want = predict_currents(smp);
    if (chk_avg) begin
      want.avg = avg;
    end
    if (chk_inst) begin
      want.inst = inst;
    end
    expected_currents.push_back(want);
  endtask

  // register write, only once the block has gone idle
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_ZERO_OFFSET: offset_reg = value[SAMPLE_W-1:0];
      REG_GAIN:        gain_reg   = value[GAIN_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // output ready, with random idling and long hold-offs
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
        hold_left = hold_left - 1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // output transfer check
  always @(posedge clk_i) begin : result_check
    currents_t got;
    currents_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (expected_currents.size() == 0) begin
        mismatch_cnt = mismatch_cnt + 1;
        if (mismatch_cnt <= MAX_REPORTS) begin
          $display("unexpected result: avg %0d inst %0d", got.avg, got.inst);
        end
      end else begin
        want = expected_currents.pop_front();
        if (got.avg !== want.avg || got.inst !== want.inst) begin
          mismatch_cnt = mismatch_cnt + 1;
          if (mismatch_cnt <= MAX_REPORTS) begin
            $display("mismatch: avg exp %0d got %0d, inst exp %0d got %0d",
                     want.avg, got.avg, want.inst, got.inst);
          end
        end
      end
    end
  end

  // stimulus
  initial begin
    int               near;
    logic [SAMPLE_W-1:0] smp;
    dir_row_t         row;

    for (int i = 0; i < WIN; i++) begin
      ring_model[i] = '0;
    end
    slot_model = 0;
    sum_model  = '0;
    offset_reg = OFFSET_RESET;
    gain_reg   = GAIN_RESET;

    // directed table: start-up window, gain and offset extremes, ignored writes
    dir_rows.push_back(srow(10'd504,  1'b0, 16'd0,     1'b1, 16'd0));
    dir_rows.push_back(srow(10'd0,    1'b0, 16'd0,     1'b0, 16'd0));
    dir_rows.push_back(srow(10'd1023, 1'b0, 16'd0,     1'b0, 16'd0));
    dir_rows.push_back(srow(10'd504,  1'b0, 16'd0,     1'b1, 16'd0));
    dir_rows.push_back(crow(REG_GAIN, 16'd0));
    dir_rows.push_back(srow(10'd1023, 1'b1, 16'd0,     1'b1, 16'd0));
    dir_rows.push_back(srow(10'd0,    1'b1, 16'd0,     1'b1, 16'd0));
    dir_rows.push_back(crow(8'd2,     16'h00FF));
    dir_rows.push_back(crow(8'hFF,    16'hFFFF));
    dir_rows.push_back(srow(10'd777,  1'b1, 16'd0,     1'b1, 16'd0));
    dir_rows.push_back(crow(REG_ZERO_OFFSET, 16'hFFFF));
    dir_rows.push_back(crow(REG_GAIN, 16'hFFFF));
    dir_rows.push_back(srow(10'd0,    1'b1, 16'hFFFF,  1'b1, 16'hFFFF));
    dir_rows.push_back(srow(10'd1023, 1'b1, 16'hFFFF,  1'b1, 16'd0));
    dir_rows.push_back(crow(REG_GAIN, 16'h0101));
    dir_rows.push_back(srow(10'd1023, 1'b0, 16'd0,     1'b0, 16'd0));
    dir_rows.push_back(crow(REG_ZERO_OFFSET, 16'd0));
    dir_rows.push_back(srow(10'd1023, 1'b0, 16'd0,     1'b0, 16'd0));
    dir_rows.push_back(crow(REG_GAIN, 16'd255));
    dir_rows.push_back(srow(10'd1023, 1'b0, 16'd0,     1'b1, 16'hFFFF));
    dir_rows.push_back(srow(10'd0,    1'b0, 16'd0,     1'b1, 16'd0));
    dir_rows.push_back(crow(REG_ZERO_OFFSET, 16'(OFFSET_RESET)));
    dir_rows.push_back(crow(REG_GAIN, 16'(GAIN_RESET)));
    dir_rows.push_back(srow(10'd600,  1'b0, 16'd0,     1'b0, 16'd0));

    // reset
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.kind == ROW_CFG) begin
        write_register(row.index, row.value);
      end else begin
        send_sample(row.value[SAMPLE_W-1:0], row.chk_avg, row.avg, row.chk_inst, row.inst);
      end
    end

    // random phases with their own settings and idle patterns
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 9;
          recv_idle_pct = 87;
          write_register(REG_ZERO_OFFSET, 16'($urandom_range(1023)));
          write_register(REG_GAIN, 16'($urandom_range(255)));
        end
        1: begin
          send_idle_pct = 87;
          recv_idle_pct = 9;
          write_register(REG_ZERO_OFFSET, 16'd0);
          write_register(REG_GAIN, 16'd255);
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          write_register(REG_ZERO_OFFSET, 16'd1023);
          write_register(REG_GAIN, 16'($urandom_range(255)));
          write_register(8'($urandom_range(255, 2)), 16'($urandom));
          // long output hold-off so the pipeline fills and stalls the input
          hold_left = HOLD_CYCLES;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // pause the sender until the block has emptied
        if (phase == 2 && n == PHASE_ITEMS / 2) begin
          @(negedge clk_i);
          s_axis_tvalid <= 1'b0;
          wait_drained();
        end
        case ($urandom_range(9))
          0: smp = '0;
          1: smp = '1;
          2: begin
            near = int'(offset_reg) + int'($urandom_range(8)) - 4;
            if (near < 0) near = 0;
            if (near > 1023) near = 1023;
            smp = SAMPLE_W'(near);
          end
          default: smp = SAMPLE_W'($urandom_range(1023));
        endcase
        send_sample(smp, 1'b0, '0, 1'b0, '0);
      end
    end

    // drain and finish
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && expected_currents.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
